// File: sv/pcc_pkg.sv
// shared types, constants and byte classification functions for the percent codec
`default_nettype none

package pcc_pkg;

    localparam logic [7:0] ESCAPE_CHAR = 8'h25;

    // decoder phase, one-hot
    typedef enum logic [3:0] {
        PH_PLAIN = 4'b0001,
        PH_HEX1  = 4'b0010,
        PH_HEX2  = 4'b0100,
        PH_DROP  = 4'b1000
    } phase_t;

    // results caused by one input item, sent in order b0, b1, b2
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       err;
        logic       str_end;
    } res_bundle_t;

    // letters, digits and - _ . ~ ; :
    function automatic logic byte_passes(input logic [7:0] b);
        logic p;
        p = ((b >= 8'h30) && (b <= 8'h39)) ||
            ((b >= 8'h41) && (b <= 8'h5A)) ||
            ((b >= 8'h61) && (b <= 8'h7A)) ||
            (b == 8'h2D) || (b == 8'h5F) || (b == 8'h2E) ||
            (b == 8'h7E) || (b == 8'h3B) || (b == 8'h3A);
        return p;
    endfunction

    // bit 4 set when b is not a hex digit of either case
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'h10;
        if ((b >= 8'h30) && (b <= 8'h39)) begin
            v = {1'b0, b[3:0]};
        end else if (((b >= 8'h41) && (b <= 8'h46)) || ((b >= 8'h61) && (b <= 8'h66))) begin
            v = {1'b0, b[3:0] + 4'd9};
        end
        return v;
    endfunction

    // lower-case hex digit
    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] d;
        if (n < 4'd10) begin
            d = 8'h30 + {4'h0, n};
        end else begin
            d = 8'h57 + {4'h0, n};
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// File: sv/percent_codec_core.sv
// top level of the streaming url percent encoder/decoder
//
// channel    | direction | tdata                  | tuser                          | tlast
// -----------+-----------+------------------------+--------------------------------+-----------
// s_axis     | in        | [7:0] in_byte          | -                              | in_last
// m_axis     | out       | [7:0] out_byte         | [0] error_flag [1] string_end  | run_last
// cfg        | in        | cfg_wdata: decode_mode | -                              | -
//
// an item waits in the input register, then its results (0 to 3)
// are loaded into the result register, which sends one result per cycle while m_axis_tready is high
// encode of a byte that needs escaping gives 3 results, every other item
// 1 (or 0 when it gives no result); sustained rate is set by the output port
// a new item is taken while the last result of the previous one is being sent
// aresetn is synchronous, active low; it clears mode, decoder state and valids
// a stall on m_axis holds all results and back-pressures s_axis via the input register
`default_nettype none

module percent_codec_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,       // decode_mode
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,    // [7:0] in_byte
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,    // [7:0] out_byte
    output logic [1:0]      m_axis_tuser,    // [0] error_flag, [1] string_end
    output logic            m_axis_tlast
);

    logic                 mode_reg;
    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;
    logic                 can_load;
    logic                 load;
    logic                 s_take;
    logic                 m_err;
    logic                 m_str_end;
    pcc_pkg::res_bundle_t bundle;

    // the held item moves on when the result register can take its results
    assign load          = in_valid_reg && can_load;
    assign s_axis_tready = !in_valid_reg || load;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= 1'b0;
            in_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (load) begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    // input payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    pcc_codec u_codec (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .decode_mode (mode_reg),
        .step_en     (load),
        .in_byte     (in_byte_reg),
        .in_last     (in_last_reg),
        .res         (bundle)
    );

    pcc_serializer u_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .bundle     (bundle),
        .can_load   (can_load),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_byte     (m_axis_tdata),
        .m_err      (m_err),
        .m_run_last (m_axis_tlast),
        .m_str_end  (m_str_end)
    );

    assign m_axis_tuser = {m_str_end, m_err};

`ifndef SYNTH
    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 8'h00 && m_axis_tlast)
        else $error("error item not a lone zero byte");
    a_escape_first: assert property (@(posedge aclk) disable iff (!aresetn)
        load && !mode_reg && !pcc_pkg::byte_passes(in_byte_reg)
        |=> m_axis_tvalid && m_axis_tdata == pcc_pkg::ESCAPE_CHAR && !m_axis_tlast)
        else $error("encoded escape does not start with percent");
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("item taken while output stalled and input register full");
`endif

endmodule

`default_nettype wire

// File: sv/pcc_codec.sv
// per-item encode/decode step with the decoder phase and pending nibble state
`default_nettype none

module pcc_codec (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 decode_mode,
    input  wire logic                 step_en,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 in_last,
    output pcc_pkg::res_bundle_t      res
);

    pcc_pkg::phase_t phase_reg, phase_next;
    logic [3:0]      nibble_reg, nibble_next;
    logic [4:0]      hv;
    logic            passes;
    logic            fault;

    assign hv     = pcc_pkg::hex_value(in_byte);
    assign passes = pcc_pkg::byte_passes(in_byte);

    always_comb begin
        phase_next  = phase_reg;
        nibble_next = nibble_reg;
        fault       = 1'b0;
        res         = '0;
        res.str_end = in_last;
        if (!decode_mode) begin
            phase_next = pcc_pkg::PH_PLAIN;
            if (passes) begin
                res.count = 2'd1;
                res.b0    = in_byte;
            end else begin
                res.count = 2'd3;
                res.b0    = pcc_pkg::ESCAPE_CHAR;
                res.b1    = pcc_pkg::hex_digit(in_byte[7:4]);
                res.b2    = pcc_pkg::hex_digit(in_byte[3:0]);
            end
        end else begin
            unique case (phase_reg)
                pcc_pkg::PH_PLAIN: begin
                    if (in_byte == pcc_pkg::ESCAPE_CHAR) begin
                        if (in_last) begin
                            fault = 1'b1;
                        end else begin
                            phase_next = pcc_pkg::PH_HEX1;
                        end
                    end else if (passes) begin
                        res.count = 2'd1;
                        res.b0    = in_byte;
                    end else begin
                        fault = 1'b1;
                    end
                end
                pcc_pkg::PH_HEX1: begin
                    if (!hv[4] && !in_last) begin
                        nibble_next = hv[3:0];
                        phase_next  = pcc_pkg::PH_HEX2;
                    end else begin
                        fault = 1'b1;
                    end
                end
                pcc_pkg::PH_HEX2: begin
                    if (!hv[4]) begin
                        phase_next = pcc_pkg::PH_PLAIN;
                        res.count  = 2'd1;
                        res.b0     = {nibble_reg, hv[3:0]};
                    end else begin
                        fault = 1'b1;
                    end
                end
                pcc_pkg::PH_DROP: begin
                    if (in_last) begin
                        phase_next = pcc_pkg::PH_PLAIN;
                    end
                end
                default: begin
                    phase_next = pcc_pkg::PH_PLAIN;
                end
            endcase
            if (fault) begin
                // one error result, then drop the rest of the string
                res.count  = 2'd1;
                res.b0     = 8'h00;
                res.err    = 1'b1;
                phase_next = in_last ? pcc_pkg::PH_PLAIN : pcc_pkg::PH_DROP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= pcc_pkg::PH_PLAIN;
            nibble_reg <= 4'h0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            nibble_reg <= nibble_next;
        end
    end

`ifndef SYNTH
    a_encode_clears_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && !decode_mode |=> phase_reg == pcc_pkg::PH_PLAIN)
        else $error("encode step left a pending escape");
    a_last_ends_string: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && decode_mode && in_last |=> phase_reg == pcc_pkg::PH_PLAIN)
        else $error("string end did not return decoder to plain text");
    a_error_single: assert property (@(posedge aclk) disable iff (!aresetn)
        res.err |-> res.count == 2'd1 && res.b0 == 8'h00)
        else $error("error bundle malformed");
`endif

endmodule

`default_nettype wire

// File: sv/pcc_serializer.sv
// result register that holds up to three results and sends one per cycle while m_ready is high
`default_nettype none

module pcc_serializer (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load,
    input  pcc_pkg::res_bundle_t      bundle,
    output logic                      can_load,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [7:0]                m_byte,
    output logic                      m_err,
    output logic                      m_run_last,
    output logic                      m_str_end
);

    logic [1:0] cnt_reg, cnt_next;
    logic [7:0] b0_reg, b0_next;
    logic [7:0] b1_reg, b1_next;
    logic [7:0] b2_reg, b2_next;
    logic       err_reg, err_next;
    logic       end_reg, end_next;
    logic       pop;

    assign m_valid    = (cnt_reg != 2'd0);
    assign pop        = m_valid && m_ready;
    // free, or its final result leaves this cycle
    assign can_load   = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);
    assign m_byte     = b0_reg;
    assign m_err      = err_reg;
    assign m_run_last = (cnt_reg == 2'd1);
    assign m_str_end  = end_reg;

    always_comb begin
        cnt_next = cnt_reg;
        b0_next  = b0_reg;
        b1_next  = b1_reg;
        b2_next  = b2_reg;
        err_next = err_reg;
        end_next = end_reg;
        if (load) begin
            cnt_next = bundle.count;
            b0_next  = bundle.b0;
            b1_next  = bundle.b1;
            b2_next  = bundle.b2;
            err_next = bundle.err;
            end_next = bundle.str_end;
        end else if (pop) begin
            cnt_next = cnt_reg - 2'd1;
            b0_next  = b1_reg;
            b1_next  = b2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        b0_reg  <= b0_next;
        b1_reg  <= b1_next;
        b2_reg  <= b2_next;
        err_reg <= err_next;
        end_reg <= end_next;
    end

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop))
        else $error("results overwritten before sent");
    a_pop_counts_down: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !load |=> cnt_reg == $past(cnt_reg) - 2'd1)
        else $error("result count did not step down");
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> cnt_reg == $past(cnt_reg))
        else $error("results moved while stalled");
`endif

endmodule

`default_nettype wire
